/* design/rc5_key_search_engine_assert.svh */
// ----------------------------------------------------------------------------
// RC5 key search engine assertion macros
// Shared property forms for the checkers of the key search engine.
// ----------------------------------------------------------------------------
`ifndef RC5_KEY_SEARCH_ENGINE_ASSERT_SVH
`define RC5_KEY_SEARCH_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define RC5KS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rc5ks: same-cycle check failed");

// Next-cycle implication, disabled while reset is applied.
`define RC5KS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rc5ks: next-cycle check failed");

`endif

/* design/rc5ks_pkg.sv */
// ----------------------------------------------------------------------------
// RC5 key search package
// Widths, constants, command and register codes, and key word helpers.
// ----------------------------------------------------------------------------
package rc5ks_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned KEY_HI_W  = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_REGS  = 6;

  localparam logic [WORD_W-1:0] RC5_P = 32'hB7E1_5163;
  localparam logic [WORD_W-1:0] RC5_Q = 32'h9E37_79B9;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLAIN_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLAIN_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH = 3'd5;

  typedef enum logic {
    UNIT_SCHED,
    UNIT_ENC
  } unit_mode_e;

  typedef struct packed {
    logic [WORD_W-1:0]   low;
    logic [KEY_HI_W-1:0] high;
  } key_pair_t;

  typedef struct packed {
    logic load;
    logic advance;
  } key_ctrl_t;

  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                               input logic [4:0] s);
    logic [2*WORD_W-1:0] t;
    t = {x, x} << s;
    return t[2*WORD_W-1:WORD_W];
  endfunction

  // Start key bytes are reversed into the two key words.
  function automatic key_pair_t swap_start_key(input logic [WORD_W-1:0] k0,
                                               input logic [KEY_HI_W-1:0] k1);
    key_pair_t r;
    r.low  = {k0[31:24], k1[7:0], k1[15:8], k1[23:16]};
    r.high = {k0[7:0], k0[15:8], k0[23:16]};
    return r;
  endfunction

  // Carry runs from the most significant byte of each word down to its
  // least significant byte, high word first.
  function automatic key_pair_t advance_key(input key_pair_t k);
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    key_pair_t         r;
    w0 = k.low;
    w1 = {8'h00, k.high};
    w1 = (w1 + 32'h0001_0000) & 32'h00FF_FFFF;
    if (w1[23:16] == 8'h00) begin
      w1 = (w1 + 32'h0000_0100) & 32'h0000_FFFF;
      if (w1[15:8] == 8'h00) begin
        w1 = (w1 + 32'h0000_0001) & 32'h0000_00FF;
        if (w1[7:0] == 8'h00) begin
          w1 = '0;
          w0 = w0 + 32'h0100_0000;
          if (w0[31:24] == 8'h00) begin
            w0 = (w0 + 32'h0001_0000) & 32'h00FF_FFFF;
            if (w0[23:16] == 8'h00) begin
              w0 = (w0 + 32'h0000_0100) & 32'h0000_FFFF;
              if (w0[15:8] == 8'h00) begin
                w0 = (w0 + 32'h0000_0001) & 32'h0000_00FF;
              end
            end
          end
        end
      end
    end
    r.low  = w0;
    r.high = w1[KEY_HI_W-1:0];
    return r;
  endfunction

endpackage

/* design/rc5ks_if.sv */
// ----------------------------------------------------------------------------
// RC5 key search channel interfaces
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface rc5ks_in_if import rc5ks_pkg::*; ;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [WORD_W-1:0]   start_key_low;
  logic [KEY_HI_W-1:0] start_key_high;

  modport source (output valid, cmd, start_key_low, start_key_high, input ready);
  modport sink   (input valid, cmd, start_key_low, start_key_high, output ready);
endinterface

interface rc5ks_out_if import rc5ks_pkg::*; ;
  logic                valid;
  logic                ready;
  logic                matched;
  logic [WORD_W-1:0]   key_word_low;
  logic [KEY_HI_W-1:0] key_word_high;

  modport source (output valid, matched, key_word_low, key_word_high, input ready);
  modport sink   (input valid, matched, key_word_low, key_word_high, output ready);
endinterface

interface rc5ks_cfg_if import rc5ks_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/rc5_key_search_engine.sv */
// ----------------------------------------------------------------------------
// RC5-32/12 key search engine
// Tests 56-bit candidate keys against one known plaintext/ciphertext pair.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i writes the IV, plaintext and target words (index 0 to 5, others
//   are dropped); it is always ready. The user must write it only while
//   idle; the block itself does not enforce this. in_i carries one item:
//   cmd 0 loads a start key, cmd 1 tests the current key and then steps it.
//   out_o returns one item per input item: the match flag and the key words
//   that were loaded or tested. A load's answer is registered. A test takes
//   3*TABLE_WORDS key schedule steps plus 2*(TABLE_WORDS/2) encryption
//   half rounds on the shared add-rotate unit, one per cycle, then the
//   compare. The unit and the subkey memory, with one write and one read
//   per cycle, set the pace. in_i.ready is low for the whole run.
//   A finished result waits in the output register while out_o.ready is
//   low; no new item is taken until it leaves.
//   Reset clears the configuration words and the key counter to zero; the
//   subkey memory needs no clearing, since each test rebuilds it.
// ----------------------------------------------------------------------------
module rc5_key_search_engine import rc5ks_pkg::*; #(
  parameter int unsigned TABLE_WORDS = 26
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rc5ks_cfg_if.sink    cfg_i,
  rc5ks_in_if.sink     in_i,
  rc5ks_out_if.source  out_o
);

  localparam int unsigned IDX_W      = $clog2(TABLE_WORDS);
  localparam int unsigned STEP_W     = $clog2(3 * TABLE_WORDS);
  localparam int unsigned SCHED_LAST = 3 * TABLE_WORDS - 1;
  localparam int unsigned ENC_LAST   = 2 * (TABLE_WORDS / 2) - 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCHED = 2'd1;
  localparam logic [1:0] ST_ENC   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [IDX_W-1:0]    idx_next;
  logic [WORD_W-1:0]   acc_a_q, acc_a_d;
  logic [WORD_W-1:0]   acc_b_q, acc_b_d;
  logic [WORD_W-1:0]   l0_q, l0_d;
  logic [WORD_W-1:0]   l1_q, l1_d;
  logic                j_q, j_d;
  logic [WORD_W-1:0]   init_q, init_d;
  logic [WORD_W-1:0]   x_q, x_d;
  logic [WORD_W-1:0]   y_q, y_d;
  logic [WORD_W-1:0]   cfg_q [CFG_REGS];
  logic [WORD_W-1:0]   mem_q [TABLE_WORDS];
  logic [WORD_W-1:0]   rdata_q;
  logic                mem_we;

  logic                out_valid_q, out_valid_d;
  logic                out_matched_q, out_matched_d;
  key_pair_t           out_key_q, out_key_d;

  logic                in_fire;
  logic                out_free;
  logic                done_fire;
  logic                first_pass;
  key_pair_t           key_cur;
  key_pair_t           key_loaded;
  key_ctrl_t           key_ctrl;

  unit_mode_e          unit_mode;
  logic [WORD_W-1:0]   unit_s;
  logic [WORD_W-1:0]   unit_a;
  logic [WORD_W-1:0]   unit_b;
  logic [WORD_W-1:0]   unit_l;
  logic [WORD_W-1:0]   unit_res_a;
  logic [WORD_W-1:0]   unit_res_b;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < CFG_REGS; r++) begin
        cfg_q[r] <= '0;
      end
    end else if (cfg_i.valid && (cfg_i.index < CFG_IDX_W'(CFG_REGS))) begin
      cfg_q[cfg_i.index] <= cfg_i.data;
    end
  end

  // Handshakes.
  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_fire   = in_i.valid && in_i.ready;
  assign done_fire = (state_q == ST_DONE) && out_free;

  assign key_loaded       = swap_start_key(in_i.start_key_low, in_i.start_key_high);
  assign key_ctrl.load    = in_fire && (in_i.cmd == CMD_LOAD);
  assign key_ctrl.advance = done_fire;

  rc5ks_key_counter u_key_counter (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (key_ctrl),
    .start_key_low_i  (in_i.start_key_low),
    .start_key_high_i (in_i.start_key_high),
    .key_o            (key_cur)
  );

  assign idx_next   = (idx_q == IDX_W'(TABLE_WORDS - 1)) ? '0 : idx_q + 1'b1;
  assign first_pass = step_q < STEP_W'(TABLE_WORDS);

  // Operand selection for the shared unit. The first two encryption steps
  // add the whitened plaintext words to the first two subkeys.
  always_comb begin
    unit_l = j_q ? l1_q : l0_q;
    if (state_q == ST_ENC) begin
      unit_mode = UNIT_ENC;
      unit_s    = rdata_q;
      priority if (idx_q[IDX_W-1:1] == '0) begin
        unit_a = idx_q[0] ? (cfg_q[REG_PLAIN_HIGH] ^ cfg_q[REG_IV_HIGH])
                          : (cfg_q[REG_PLAIN_LOW] ^ cfg_q[REG_IV_LOW]);
        unit_b = '0;
      end else if (idx_q[0]) begin
        unit_a = y_q;
        unit_b = x_q;
      end else begin
        unit_a = x_q;
        unit_b = y_q;
      end
    end else begin
      unit_mode = UNIT_SCHED;
      unit_s    = first_pass ? init_q : rdata_q;
      unit_a    = acc_a_q;
      unit_b    = acc_b_q;
    end
  end

  rc5ks_add_rot_unit u_add_rot (
    .mode_i   (unit_mode),
    .s_word_i (unit_s),
    .a_i      (unit_a),
    .b_i      (unit_b),
    .l_word_i (unit_l),
    .res_a_o  (unit_res_a),
    .res_b_o  (unit_res_b)
  );

  // Subkey memory: one write and one registered read per cycle. The read
  // always fetches the entry that the next step uses.
  assign mem_we = (state_q == ST_SCHED);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= unit_res_a;
    end
    rdata_q <= mem_q[idx_next];
  end

  // Sequencer.
  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    idx_d         = idx_q;
    acc_a_d       = acc_a_q;
    acc_b_d       = acc_b_q;
    l0_d          = l0_q;
    l1_d          = l1_q;
    j_d           = j_q;
    init_d        = init_q;
    x_d           = x_q;
    y_d           = y_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_matched_d = out_matched_q;
    out_key_d     = out_key_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.cmd == CMD_LOAD) begin
            out_valid_d   = 1'b1;
            out_matched_d = 1'b0;
            out_key_d     = key_loaded;
          end else begin
            state_d = ST_SCHED;
            step_d  = '0;
            idx_d   = '0;
            acc_a_d = '0;
            acc_b_d = '0;
            l0_d    = key_cur.low;
            l1_d    = {{(WORD_W - KEY_HI_W){1'b0}}, key_cur.high};
            j_d     = 1'b0;
            init_d  = RC5_P;
          end
        end
      end
      ST_SCHED: begin
        acc_a_d = unit_res_a;
        acc_b_d = unit_res_b;
        if (j_q) begin
          l1_d = unit_res_b;
        end else begin
          l0_d = unit_res_b;
        end
        j_d    = !j_q;
        init_d = init_q + RC5_Q;
        idx_d  = idx_next;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(SCHED_LAST)) begin
          state_d = ST_ENC;
          idx_d   = '0;
        end
      end
      ST_ENC: begin
        if (idx_q[0]) begin
          y_d = unit_res_a;
        end else begin
          x_d = unit_res_a;
        end
        idx_d = idx_next;
        if (idx_q == IDX_W'(ENC_LAST)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d       = ST_IDLE;
          out_valid_d   = 1'b1;
          out_matched_d = (x_q == cfg_q[REG_TARGET_LOW]) &&
                          (y_q == cfg_q[REG_TARGET_HIGH]);
          out_key_d     = key_cur;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      acc_a_q     <= '0;
      acc_b_q     <= '0;
      step_q      <= '0;
      idx_q       <= '0;
      j_q         <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      acc_a_q     <= acc_a_d;
      acc_b_q     <= acc_b_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      j_q         <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l0_q          <= l0_d;
    l1_q          <= l1_d;
    init_q        <= init_d;
    x_q           <= x_d;
    y_q           <= y_d;
    out_matched_q <= out_matched_d;
    out_key_q     <= out_key_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.matched       = out_matched_q;
  assign out_o.key_word_low  = out_key_q.low;
  assign out_o.key_word_high = out_key_q.high;

endmodule

/* design/rc5ks_add_rot_unit.sv */
// ----------------------------------------------------------------------------
// RC5 shared add-rotate unit
// One key schedule step or one encryption half round per cycle.
// ----------------------------------------------------------------------------
module rc5ks_add_rot_unit import rc5ks_pkg::*; (
  input  unit_mode_e        mode_i,
  input  logic [WORD_W-1:0] s_word_i,
  input  logic [WORD_W-1:0] a_i,
  input  logic [WORD_W-1:0] b_i,
  input  logic [WORD_W-1:0] l_word_i,
  output logic [WORD_W-1:0] res_a_o,
  output logic [WORD_W-1:0] res_b_o
);

  logic [WORD_W-1:0] sched_a;
  logic [WORD_W-1:0] amt_sum;
  logic [WORD_W-1:0] rot_in;
  logic [4:0]        rot_amt;
  logic [WORD_W-1:0] rot_out;

  assign sched_a = rotl32(s_word_i + a_i + b_i, 5'd3);
  assign amt_sum = sched_a + b_i;

  // In encryption mode a_i is the word being updated and b_i the other word.
  always_comb begin
    unique case (mode_i)
      UNIT_SCHED: begin
        rot_in  = l_word_i + amt_sum;
        rot_amt = amt_sum[4:0];
      end
      UNIT_ENC: begin
        rot_in  = a_i ^ b_i;
        rot_amt = b_i[4:0];
      end
      default: begin
        rot_in  = a_i ^ b_i;
        rot_amt = b_i[4:0];
      end
    endcase
  end

  assign rot_out = rotl32(rot_in, rot_amt);
  assign res_a_o = (mode_i == UNIT_SCHED) ? sched_a : rot_out + s_word_i;
  assign res_b_o = rot_out;

endmodule

/* design/rc5ks_key_counter.sv */
// ----------------------------------------------------------------------------
// RC5 key counter
// Holds the current key words, loads a start key and steps to the next key.
// ----------------------------------------------------------------------------
module rc5ks_key_counter import rc5ks_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  key_ctrl_t           ctrl_i,
  input  logic [WORD_W-1:0]   start_key_low_i,
  input  logic [KEY_HI_W-1:0] start_key_high_i,
  output key_pair_t           key_o
);

  key_pair_t key_q;
  key_pair_t key_d;

  always_comb begin
    priority if (ctrl_i.load) begin
      key_d = swap_start_key(start_key_low_i, start_key_high_i);
    end else if (ctrl_i.advance) begin
      key_d = advance_key(key_q);
    end else begin
      key_d = key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

/* design/rc5ks_checker.sv */
// ----------------------------------------------------------------------------
// RC5 key search port checker
// Watches the top-level channels for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "rc5_key_search_engine_assert.svh"

module rc5ks_checker import rc5ks_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_cmd_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_matched_i
);

  logic in_fire;
  logic test_fire;
  logic load_fire;

  assign in_fire   = in_valid_i && in_ready_i;
  assign test_fire = in_fire && (in_cmd_i == CMD_TEST);
  assign load_fire = in_fire && (in_cmd_i == CMD_LOAD);

  `RC5KS_ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `RC5KS_ASSERT_NEXT(a_test_busy, clk_i, rst_ni, test_fire, !in_ready_i && !out_valid_i)
  `RC5KS_ASSERT_NEXT(a_load_result, clk_i, rst_ni, load_fire, out_valid_i && !out_matched_i)
  `RC5KS_ASSERT_SAME(a_ready_out_free, clk_i, rst_ni, in_ready_i, !out_valid_i || out_ready_i)

endmodule

bind rc5_key_search_engine rc5ks_checker u_rc5ks_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_cmd_i      (in_i.cmd),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_matched_i (out_o.matched)
);

/* sim/tb_rc5_key_search_engine.sv */
// ----------------------------------------------------------------------------
// RC5 key search engine testbench
// Drives load and test items through the input channel and programs the IV,
// plaintext and target words between phases. A scoreboard runs its own
// RC5-32/12 key schedule and encryption to predict every result item.
// ----------------------------------------------------------------------------
module tb_rc5_key_search_engine;
  import rc5ks_pkg::*;

  localparam int unsigned TABLE_WORDS    = 26;
  localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
  localparam int unsigned PHASES         = 14;
  localparam int unsigned PHASE_ITEMS    = 100;

  // Indexes past the last register; the block drops writes to them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_0 = CFG_IDX_W'(CFG_REGS);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_1 = CFG_IDX_W'(CFG_REGS + 1);

  typedef struct packed {
    logic                matched;
    logic [WORD_W-1:0]   key_low;
    logic [KEY_HI_W-1:0] key_high;
  } key_result_t;

  class rc5_key_tracker;
    key_pair_t         key;
    logic [WORD_W-1:0] regs [CFG_REGS];
    key_result_t       expected_results [$];
    int                errors;
    int                loads;
    int                tests;
    int                hits;
    int                reg_writes;

    function new();
      key = '0;
      foreach (regs[r]) regs[r] = '0;
    endfunction

    // The key words form one 56-bit counter whose least significant byte is
    // the top byte of the high word and whose most significant byte is the
    // bottom byte of the low word.
    static function logic [55:0] counter_of(key_pair_t k);
      return {k.low[7:0], k.low[15:8], k.low[23:16], k.low[31:24],
              k.high[7:0], k.high[15:8], k.high[23:16]};
    endfunction

    static function key_pair_t words_of(logic [55:0] c);
      key_pair_t k;
      k.low  = {c[31:24], c[39:32], c[47:40], c[55:48]};
      k.high = {c[7:0], c[15:8], c[23:16]};
      return k;
    endfunction

    static function logic [WORD_W-1:0] rot_left(logic [WORD_W-1:0] v, logic [4:0] amt);
      if (amt == 5'd0) return v;
      return (v << amt) | (v >> (WORD_W - amt));
    endfunction

    // Key schedule over the subkey table, then the IV-xored block is
    // encrypted. Returns the two ciphertext words, low word on top.
    function logic [63:0] rc5_cipher(key_pair_t k);
      logic [WORD_W-1:0] sub [TABLE_WORDS];
      logic [WORD_W-1:0] mix [2];
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      int                i;
      int                j;
      int                n;
      sub[0] = RC5_P;
      for (n = 1; n < TABLE_WORDS; n++) sub[n] = sub[n-1] + RC5_Q;
      mix[0] = k.low;
      mix[1] = {8'h00, k.high};
      a = '0;
      b = '0;
      i = 0;
      j = 0;
      for (n = 0; n < 3 * ((TABLE_WORDS > 2) ? TABLE_WORDS : 2); n++) begin
        a = rot_left(sub[i] + a + b, 5'd3);
        sub[i] = a;
        b = rot_left(mix[j] + a + b, 5'(a + b));
        mix[j] = b;
        i = (i == TABLE_WORDS - 1) ? 0 : i + 1;
        j = 1 - j;
      end
      a = (regs[REG_PLAIN_LOW] ^ regs[REG_IV_LOW]) + sub[0];
      b = (regs[REG_PLAIN_HIGH] ^ regs[REG_IV_HIGH]) + sub[1];
      for (n = 1; n <= TABLE_WORDS / 2 - 1; n++) begin
        a = rot_left(a ^ b, b[4:0]) + sub[2*n];
        b = rot_left(b ^ a, a[4:0]) + sub[2*n+1];
      end
      return {a, b};
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      reg_writes++;
      if (idx < CFG_REGS) regs[idx] = data;
    endfunction

    function void accept_item(logic cmd, logic [WORD_W-1:0] k0, logic [KEY_HI_W-1:0] k1);
      key_result_t r;
      if (cmd == CMD_LOAD) begin
        key.low  = {k0[31:24], k1[7:0], k1[15:8], k1[23:16]};
        key.high = {k0[7:0], k0[15:8], k0[23:16]};
        r.matched = 1'b0;
        loads++;
      end else begin
        r.matched = (rc5_cipher(key) == {regs[REG_TARGET_LOW], regs[REG_TARGET_HIGH]});
        tests++;
        if (r.matched) hits++;
      end
      r.key_low  = key.low;
      r.key_high = key.high;
      expected_results.push_back(r);
      if (cmd == CMD_TEST) key = words_of(counter_of(key) + 56'd1);
    endfunction

    function void check_result(logic matched, logic [WORD_W-1:0] lo,
                               logic [KEY_HI_W-1:0] hi);
      key_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result item with nothing pending: matched %b key %h %h",
                 $time, matched, lo, hi);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (matched !== want.matched) begin
        $display("%0t: matched mismatch, expected %b, got %b", $time, want.matched, matched);
        errors++;
      end
      if (lo !== want.key_low) begin
        $display("%0t: key_word_low mismatch, expected %h, got %h", $time, want.key_low, lo);
        errors++;
      end
      if (hi !== want.key_high) begin
        $display("%0t: key_word_high mismatch, expected %h, got %h", $time, want.key_high, hi);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  rc5ks_cfg_if cfg_if ();
  rc5ks_in_if  in_if ();
  rc5ks_out_if out_if ();

  rc5_key_search_engine #(
    .TABLE_WORDS(TABLE_WORDS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  rc5_key_tracker sb = new();
  bit             no_idle;
  int             hold_cycles;

  always #4 clk_i = ~clk_i;

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [WORD_W-1:0] draw_word();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Counter values with a run of 0xFF bytes at the bottom, so that tests
  // soon ripple a carry through several bytes or wrap the whole key space.
  function automatic logic [55:0] draw_counter();
    logic [55:0] c;
    int          ones;
    int          b;
    c[31:0]  = $urandom;
    c[55:32] = 24'($urandom);
    ones = $urandom_range(0, 7);
    for (b = 0; b < ones; b++) c[8*b +: 8] = 8'hFF;
    return c;
  endfunction

  task automatic send_item(logic cmd, logic [WORD_W-1:0] k0, logic [KEY_HI_W-1:0] k1);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.cmd            <= cmd;
    in_if.start_key_low  <= k0;
    in_if.start_key_high <= k1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.accept_item(cmd, k0, k1);
  endtask

  task automatic send_test();
    send_item(CMD_TEST, $urandom, KEY_HI_W'($urandom));
  endtask

  // Loads the start key whose byte-reversed key words equal the counter.
  task automatic send_load_ctr(logic [55:0] c);
    key_pair_t k;
    k = rc5_key_tracker::words_of(c);
    send_item(CMD_LOAD, {k.low[31:24], k.high[7:0], k.high[15:8], k.high[23:16]},
              {k.low[7:0], k.low[15:8], k.low[23:16]});
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // With exact cleared, only the high target word is off by one bit.
  task automatic aim_target(key_pair_t k, bit exact);
    logic [63:0] ct;
    ct = sb.rc5_cipher(k);
    if (!exact) ct[0] = ~ct[0];
    write_cfg(REG_TARGET_LOW, ct[63:32]);
    write_cfg(REG_TARGET_HIGH, ct[31:0]);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Result side: a random stall before each item, or one long hold on request.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = draw_wait();
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      sb.check_result(out_if.matched, out_if.key_word_low, out_if.key_word_high);
    end
  end

  initial begin
    logic [55:0] ctr;
    int          ahead;
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.cmd            = CMD_TEST;
    in_if.start_key_low  = '0;
    in_if.start_key_high = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = REG_IV_LOW;
    cfg_if.data          = '0;
    no_idle              = 1'b0;
    hold_cycles          = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Tests before any load use key words zero, then byte reversal on load,
    // the wrap of the all-ones key and carries across byte boundaries.
    send_test();
    send_test();
    send_item(CMD_LOAD, '0, '0);
    send_item(CMD_LOAD, '1, '1);
    send_test();
    send_test();
    send_load_ctr(56'h00_0000_0000_FFFF);
    send_test();
    send_test();
    send_load_ctr(56'h00_0000_00FF_FFFF);
    send_test();
    send_test();
    send_load_ctr(56'h00_FFFF_FFFF_FFFF);
    send_test();
    send_test();
    drain_results();

    write_cfg(REG_IV_LOW, '1);
    write_cfg(REG_IV_HIGH, '0);
    write_cfg(REG_PLAIN_LOW, '0);
    write_cfg(REG_PLAIN_HIGH, '1);
    write_cfg(REG_SPARE_0, $urandom);
    write_cfg(REG_SPARE_1, $urandom);
    aim_target(sb.key, 1'b1);
    cfg_if.valid <= 1'b0;
    send_test();
    send_test();
    drain_results();

    write_cfg(REG_IV_HIGH, '1);
    write_cfg(REG_PLAIN_LOW, '1);
    aim_target(sb.key, 1'b0);
    cfg_if.valid <= 1'b0;
    send_test();
    send_item(CMD_LOAD, $urandom, KEY_HI_W'($urandom));
    send_test();

    // Random phases: each loads a start key and walks it forward, most of
    // them with the target set to the ciphertext of a key a few steps ahead.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      no_idle = (p % 4 == 1);
      write_cfg(REG_IV_LOW, draw_word());
      write_cfg(REG_IV_HIGH, draw_word());
      write_cfg(REG_PLAIN_LOW, draw_word());
      write_cfg(REG_PLAIN_HIGH, draw_word());
      if ($urandom_range(0, 3) == 0) write_cfg(REG_SPARE_1, $urandom);
      ctr = draw_counter();
      ahead = $urandom_range(0, 30);
      if (p % 3 != 2) begin
        aim_target(rc5_key_tracker::words_of(ctr + 56'(ahead)), 1'b1);
      end else begin
        write_cfg(REG_TARGET_LOW, draw_word());
        write_cfg(REG_TARGET_HIGH, draw_word());
      end
      cfg_if.valid <= 1'b0;
      // The result side stops for a long time while items keep coming.
      if (p == 2) hold_cycles = 600;
      send_load_ctr(ctr);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i > ahead && $urandom_range(0, 15) == 0) send_load_ctr(draw_counter());
        else send_test();
      end
    end

    drain_results();
    repeat (4 * TABLE_WORDS + 20) @(posedge clk_i);
    $display("Covered %0d key loads and %0d key tests, %0d of them hitting the target.",
             sb.loads, sb.tests, sb.hits);
    $display("Made %0d register writes, unmapped indexes and all-zero/all-one words included.",
             sb.reg_writes);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("Timeout with %0d result items still pending.", sb.expected_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
